// ===== sv/klx_pkg.sv =====
// Package for the keyword/operator lexer: token kinds, token and batch types,
// keyword table and byte classification helpers. No dependencies.
package klx_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int KIND_W          = 6;
    localparam int FIELD_W         = 16;
    localparam int NUM_KW          = 11;
    localparam int KW_MAX_LEN      = 6;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_CONST   = 6'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 6'd1;
    localparam logic [KIND_W-1:0] KIND_KW_BASE = 6'd2;
    localparam logic [KIND_W-1:0] KIND_GT      = 6'd13;
    localparam logic [KIND_W-1:0] KIND_GTE     = 6'd14;
    localparam logic [KIND_W-1:0] KIND_LT      = 6'd15;
    localparam logic [KIND_W-1:0] KIND_LTE     = 6'd16;
    localparam logic [KIND_W-1:0] KIND_QUEST   = 6'd17;
    localparam logic [KIND_W-1:0] KIND_DOT     = 6'd18;
    localparam logic [KIND_W-1:0] KIND_BSLASH  = 6'd19;
    localparam logic [KIND_W-1:0] KIND_LBRACK  = 6'd20;
    localparam logic [KIND_W-1:0] KIND_RBRACK  = 6'd21;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 6'd22;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 6'd23;
    localparam logic [KIND_W-1:0] KIND_HASH    = 6'd24;
    localparam logic [KIND_W-1:0] KIND_COMMA   = 6'd25;
    localparam logic [KIND_W-1:0] KIND_COLON   = 6'd26;
    localparam logic [KIND_W-1:0] KIND_SEMI    = 6'd27;
    localparam logic [KIND_W-1:0] KIND_STAR    = 6'd28;
    localparam logic [KIND_W-1:0] KIND_DIV     = 6'd29;
    localparam logic [KIND_W-1:0] KIND_MINUS   = 6'd30;
    localparam logic [KIND_W-1:0] KIND_PLUS    = 6'd31;
    localparam logic [KIND_W-1:0] KIND_EQ      = 6'd32;
    localparam logic [KIND_W-1:0] KIND_ASSIGN  = 6'd33;
    localparam logic [KIND_W-1:0] KIND_NEQ     = 6'd34;
    localparam logic [KIND_W-1:0] KIND_NOT     = 6'd35;
    localparam logic [KIND_W-1:0] KIND_AT      = 6'd36;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 6'd37;
    localparam logic [KIND_W-1:0] KIND_END     = 6'd38;

    // Byte codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Keywords, packed big-end first, in kind order
    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        48'h0000_0066_6F72,  // for
        48'h0000_0000_6279,  // by
        48'h0000_0000_646F,  // do
        48'h0070_7269_6E74,  // print
        48'h0000_0000_6966,  // if
        48'h0000_7468_656E,  // then
        48'h0000_656C_7365,  // else
        48'h0000_0069_6E74,  // int
        48'h0000_0061_6E64,  // and
        48'h0000_0000_6F72,  // or
        48'h7265_7475_726E   // return
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd3, 3'd2, 3'd2, 3'd5, 3'd2, 3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd6
    };

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] tbegin;
        logic [FIELD_W-1:0] tfinish;
        logic [FIELD_W-1:0] line;
        logic               fin;
    } t_token;

    // Up to three tokens caused by one byte
    typedef struct packed {
        t_token [2:0] tok;
        logic [1:0]   cnt;
    } t_batch;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_newline(input logic [7:0] c);
        return (c == CH_LF) || (c == CH_CR);
    endfunction

    // Identifier or keyword kind from the buffered first bytes
    function automatic logic [KIND_W-1:0] kw_kind(input logic [47:0] kbuf,
                                                  input logic [2:0]  klen);
        logic [KIND_W-1:0] k;
        k = KIND_IDENT;
        for (int i = 0; i < NUM_KW; i++) begin
            if ((klen == KW_LEN[i]) && (kbuf == KW_TEXT[i])) begin
                k = KIND_KW_BASE + KIND_W'(i);
            end
        end
        return k;
    endfunction

    // One-byte symbols; anything unlisted is an unknown byte
    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            8'h3F:   k = KIND_QUEST;
            8'h2E:   k = KIND_DOT;
            8'h5C:   k = KIND_BSLASH;
            8'h5B:   k = KIND_LBRACK;
            8'h5D:   k = KIND_RBRACK;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h23:   k = KIND_HASH;
            8'h2C:   k = KIND_COMMA;
            8'h3A:   k = KIND_COLON;
            8'h3B:   k = KIND_SEMI;
            8'h2A:   k = KIND_STAR;
            8'h2D:   k = KIND_MINUS;
            8'h2B:   k = KIND_PLUS;
            8'h40:   k = KIND_AT;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

// ===== sv/klx_if.sv =====
// Valid/ready channel interfaces for the lexer: text bytes in, tokens out.
// Depends on klx_pkg for field widths.
interface klx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface klx_out_if;
    import klx_pkg::*;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  token_kind;
    logic [FIELD_W-1:0] token_begin;
    logic [FIELD_W-1:0] token_finish;
    logic [FIELD_W-1:0] line_number;
    logic               final_token;

    modport source (output valid, output token_kind, output token_begin,
                    output token_finish, output line_number, output final_token,
                    input ready);
    modport sink   (input valid, input token_kind, input token_begin,
                    input token_finish, input line_number, input final_token,
                    output ready);
endinterface

// ===== sv/klx_scan.sv =====
// Scanner: lexer state and the per-byte decision, giving up to three tokens.
// Depends on klx_pkg.
module klx_scan #(
    parameter int OFFSET_BITS = klx_pkg::OFFSET_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic [7:0]      i_char,
    input  logic            i_eot,
    output klx_pkg::t_batch o_batch
);
    import klx_pkg::*;

    typedef enum logic [8:0] {
        M_IDLE    = 9'b0_0000_0001,
        M_NUM     = 9'b0_0000_0010,
        M_IDENT   = 9'b0_0000_0100,
        M_GT      = 9'b0_0000_1000,
        M_LT      = 9'b0_0001_0000,
        M_EQ      = 9'b0_0010_0000,
        M_BANG    = 9'b0_0100_0000,
        M_SLASH   = 9'b0_1000_0000,
        M_COMMENT = 9'b1_0000_0000
    } t_mode;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
    localparam logic [FIELD_W-1:0]     LINE_MAX = '1;

    t_mode                  r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_off,  n_off;
    logic [OFFSET_BITS-1:0] r_pend, n_pend;
    logic [FIELD_W-1:0]     r_line, n_line;
    logic [47:0]            r_kbuf, n_kbuf;
    logic [2:0]             r_klen, n_klen;

    // Kind of the pending token if it ends now; none when idle or in a comment
    function automatic logic pend_kind(input t_mode m, input logic [KIND_W-1:0] kw,
                                       output logic [KIND_W-1:0] k);
        logic v;
        v = 1'b1;
        case (m)
            M_NUM:   k = KIND_CONST;
            M_IDENT: k = kw;
            M_GT:    k = KIND_GT;
            M_LT:    k = KIND_LT;
            M_EQ:    k = KIND_ASSIGN;
            M_BANG:  k = KIND_NOT;
            M_SLASH: k = KIND_DIV;
            default: begin
                k = KIND_UNKNOWN;
                v = 1'b0;
            end
        endcase
        return v;
    endfunction

    function automatic t_token mk_tok(input logic [KIND_W-1:0] kind,
                                      input logic [OFFSET_BITS-1:0] b,
                                      input logic [OFFSET_BITS-1:0] f,
                                      input logic [FIELD_W-1:0] line,
                                      input logic fin);
        t_token t;
        t.kind    = kind;
        t.tbegin  = FIELD_W'(b);
        t.tfinish = FIELD_W'(f);
        t.line    = line;
        t.fin     = fin;
        return t;
    endfunction

    // Next state and tokens for one byte
    always_comb begin
        logic [OFFSET_BITS-1:0] pos;
        logic [OFFSET_BITS-1:0] nxt;
        logic                   fresh;
        logic                   pv;
        logic [KIND_W-1:0]      pk;
        t_token                 tk;

        n_mode = r_mode;
        n_off  = r_off;
        n_pend = r_pend;
        n_line = r_line;
        n_kbuf = r_kbuf;
        n_klen = r_klen;
        o_batch = '0;
        pos   = r_off;
        nxt   = (r_off == OFF_MAX) ? r_off : r_off + 1'b1;
        fresh = 1'b1;
        pv    = 1'b0;
        pk    = KIND_UNKNOWN;
        tk    = '0;

        // continue the pending token where the byte allows
        case (r_mode)
            M_NUM: begin
                if (is_digit(i_char)) fresh = 1'b0;
            end
            M_IDENT: begin
                if (is_letter(i_char) || is_digit(i_char)) begin
                    fresh = 1'b0;
                    if (r_klen < 3'd6) begin
                        n_kbuf = {r_kbuf[39:0], i_char};
                        n_klen = r_klen + 3'd1;
                    end else begin
                        n_klen = 3'd7;
                    end
                end
            end
            M_GT, M_LT, M_EQ, M_BANG: begin
                if (i_char == CH_EQ) begin
                    case (r_mode)
                        M_GT:    pk = KIND_GTE;
                        M_LT:    pk = KIND_LTE;
                        M_EQ:    pk = KIND_EQ;
                        default: pk = KIND_NEQ;
                    endcase
                    o_batch.tok[0] = mk_tok(pk, r_pend, nxt, r_line, 1'b0);
                    o_batch.cnt    = 2'd1;
                    n_mode = M_IDLE;
                    fresh  = 1'b0;
                end
            end
            M_SLASH: begin
                if (i_char == CH_SLASH) begin
                    n_mode = M_COMMENT;
                    fresh  = 1'b0;
                end
            end
            M_COMMENT: begin
                if (is_newline(i_char)) n_mode = M_IDLE;
                else                    fresh  = 1'b0;
            end
            default: n_mode = M_IDLE;
        endcase

        // byte starts something new: close the pending token first
        if (fresh) begin
            pv = pend_kind(n_mode, kw_kind(r_kbuf, r_klen), pk);
            if (pv) begin
                o_batch.tok[0] = mk_tok(pk, r_pend, pos, r_line, 1'b0);
                o_batch.cnt    = 2'd1;
            end
            n_mode = M_IDLE;
            if (is_newline(i_char)) begin
                if (r_line != LINE_MAX) n_line = r_line + 1'b1;
            end else if ((i_char == CH_SPACE) || (i_char == CH_TAB)) begin
                n_mode = M_IDLE;
            end else if (is_digit(i_char)) begin
                n_mode = M_NUM;
                n_pend = pos;
            end else if (is_letter(i_char)) begin
                n_mode = M_IDENT;
                n_pend = pos;
                n_kbuf = {40'd0, i_char};
                n_klen = 3'd1;
            end else if (i_char == CH_GT) begin
                n_mode = M_GT;
                n_pend = pos;
            end else if (i_char == CH_LT) begin
                n_mode = M_LT;
                n_pend = pos;
            end else if (i_char == CH_EQ) begin
                n_mode = M_EQ;
                n_pend = pos;
            end else if (i_char == CH_BANG) begin
                n_mode = M_BANG;
                n_pend = pos;
            end else if (i_char == CH_SLASH) begin
                n_mode = M_SLASH;
                n_pend = pos;
            end else begin
                tk = mk_tok(single_kind(i_char), pos, nxt, n_line, 1'b0);
                case (o_batch.cnt)
                    2'd0:    o_batch.tok[0] = tk;
                    default: o_batch.tok[1] = tk;
                endcase
                o_batch.cnt = o_batch.cnt + 2'd1;
            end
        end

        n_off = nxt;

        // end of text: flush, end marker, back to reset values
        if (i_eot) begin
            pv = pend_kind(n_mode, kw_kind(n_kbuf, n_klen), pk);
            if (pv) begin
                tk = mk_tok(pk, n_pend, n_off, n_line, 1'b0);
                case (o_batch.cnt)
                    2'd0:    o_batch.tok[0] = tk;
                    2'd1:    o_batch.tok[1] = tk;
                    default: o_batch.tok[2] = tk;
                endcase
                o_batch.cnt = o_batch.cnt + 2'd1;
            end
            tk = mk_tok(KIND_END, n_off, n_off, n_line, 1'b1);
            case (o_batch.cnt)
                2'd0:    o_batch.tok[0] = tk;
                2'd1:    o_batch.tok[1] = tk;
                default: o_batch.tok[2] = tk;
            endcase
            o_batch.cnt = o_batch.cnt + 2'd1;
            n_mode = M_IDLE;
            n_off  = '0;
            n_pend = '0;
            n_line = FIELD_W'(1);
            n_kbuf = '0;
            n_klen = '0;
        end
    end

    // State registers, updated when the held byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_off  <= '0;
            r_pend <= '0;
            r_line <= FIELD_W'(1);
            r_kbuf <= '0;
            r_klen <= '0;
        end else if (i_load) begin
            r_mode <= n_mode;
            r_off  <= n_off;
            r_pend <= n_pend;
            r_line <= n_line;
            r_kbuf <= n_kbuf;
            r_klen <= n_klen;
        end
    end

endmodule

// ===== sv/klx_outbuf.sv =====
// Result register: holds the tokens of one byte and hands them out one beat
// at a time. Depends on klx_pkg and klx_out_if.
module klx_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  klx_pkg::t_batch  i_batch,
    output logic             o_room,
    klx_out_if.source        o_token
);
    import klx_pkg::*;

    t_batch     r_batch;
    logic [1:0] r_cnt;
    logic [1:0] r_idx;
    logic       fire;
    logic       last;
    t_token     cur;

    assign fire   = o_token.valid && o_token.ready;
    assign last   = (r_idx == (r_cnt - 2'd1));
    assign o_room = (r_cnt == 2'd0) || (fire && last);

    // select the token under the read index
    always_comb begin
        case (r_idx)
            2'd0:    cur = r_batch.tok[0];
            2'd1:    cur = r_batch.tok[1];
            default: cur = r_batch.tok[2];
        endcase
    end

    assign o_token.valid        = (r_cnt != 2'd0);
    assign o_token.token_kind   = cur.kind;
    assign o_token.token_begin  = cur.tbegin;
    assign o_token.token_finish = cur.tfinish;
    assign o_token.line_number  = cur.line;
    assign o_token.final_token  = cur.fin;

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_batch <= i_batch;
        end
    end

    // beat count and read index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_batch.cnt;
            r_idx <= '0;
        end else if (fire) begin
            if (last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

// ===== sv/keyword_operator_lexer.sv =====
// Keyword/operator lexer top level: byte input register, scanner, result register.
// Path: a byte accepted into the input register is scanned, and its tokens are loaded into
// the result register, which drives the port. Throughput: one byte per cycle while the result
// register has room; a byte that causes several tokens (at most three) holds it until each has gone out.
// Reset: synchronous active-low; offset 0, line 1, no pending token, buffers empty.
// Depends on klx_pkg, klx_if, klx_scan and klx_outbuf.
module keyword_operator_lexer #(
    parameter int OFFSET_BITS = klx_pkg::OFFSET_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    klx_in_if.sink    i_byte,
    klx_out_if.source o_token
);
    import klx_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_eot;
    logic       room;
    logic       adv;
    t_batch     batch;

    assign adv          = r_in_valid && room;
    assign i_byte.ready = !r_in_valid || adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_char <= i_byte.char_code;
            r_eot  <= i_byte.end_of_text;
        end
    end

    klx_scan #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_char  (r_char),
        .i_eot   (r_eot),
        .o_batch (batch)
    );

    klx_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_batch (batch),
        .o_room  (room),
        .o_token (o_token)
    );

endmodule
